>>> rtl/pcss_pkg.sv
package pcss_pkg;

    // Block dimensions.
    localparam int CHANNELS    = 4;
    localparam int COUNT_BITS  = 24;
    localparam int CHAN_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CODE_W      = 12;
    localparam int SQUARE_W    = 2 * CODE_W;
    localparam int SUM_W       = 36;
    localparam int SQ_SUM_W    = 48;
    localparam int OUT_COUNT_W = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CHAN_IDX_W-1:0] LAST_CHAN = CHAN_IDX_W'(CHANNELS - 1);

    // Operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OVER_LIMIT  = 2'd0,
        REG_UNDER_LIMIT = 2'd1,
        REG_TEMP_HIGH   = 2'd2,
        REG_TEMP_LOW    = 2'd3
    } cfg_reg_t;

    // One channel's statistics as held in the store.
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [SUM_W-1:0]      sum;
        logic [SQ_SUM_W-1:0]   square_sum;
        logic [CODE_W-1:0]     min_code;
        logic [CODE_W-1:0]     max_code;
        logic [COUNT_BITS-1:0] over;
        logic [COUNT_BITS-1:0] under;
        logic [COUNT_BITS-1:0] fault;
    } stat_rec_t;

    localparam stat_rec_t RESET_REC = '{
        count:      '0,
        sum:        '0,
        square_sum: '0,
        min_code:   '1,
        max_code:   '0,
        over:       '0,
        under:      '0,
        fault:      '0
    };

    // Store read and write requests.
    typedef struct packed {
        logic [CHAN_IDX_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic                  we;
        logic [CHAN_IDX_W-1:0] addr;
        stat_rec_t             data;
        logic                  set_valid;
    } store_wr_t;

    // Saturating increment of a counter.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (v == '1) ? v : v + COUNT_BITS'(1);
        return r;
    endfunction

    // A counter reported on the 24-bit output fields.
    function automatic logic [OUT_COUNT_W-1:0] to_out_count(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_COUNT_W-1:0];
    endfunction

endpackage

>>> rtl/pcss_in_if.sv
interface pcss_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         channel;
    logic [11:0]        raw_code;
    logic [7:0]         status_bits;
    logic [31:0]        seq_number;
    logic signed [15:0] temperature;

    modport source (
        output valid, opcode, channel, raw_code, status_bits, seq_number, temperature,
        input  ready
    );

    modport sink (
        input  valid, opcode, channel, raw_code, status_bits, seq_number, temperature,
        output ready
    );
endinterface

>>> rtl/pcss_out_if.sv
interface pcss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel_index;
    logic [23:0] sample_count;
    logic [35:0] code_sum;
    logic [47:0] code_square_sum;
    logic [11:0] min_code;
    logic [11:0] max_code;
    logic [23:0] over_count;
    logic [23:0] under_count;
    logic [23:0] fault_count;
    logic [23:0] gap_count;
    logic [23:0] anomaly_count;
    logic        last;

    modport source (
        output valid, channel_index, sample_count, code_sum, code_square_sum, min_code,
               max_code, over_count, under_count, fault_count, gap_count, anomaly_count,
               last,
        input  ready
    );

    modport sink (
        input  valid, channel_index, sample_count, code_sum, code_square_sum, min_code,
               max_code, over_count, under_count, fault_count, gap_count, anomaly_count,
               last,
        output ready
    );
endinterface

>>> rtl/per_channel_sample_statistics.sv
// Samples: one transfer per cycle unless a report is in progress; a sample produces
// no result. Report: once accepted, the store is swept one channel per cycle unless the
// output stalls, and the input is held off during the sweep; each channel passes the
// update stage and then the output register, and the results follow at the same rate.
// Reset clears the statistics (per-entry valid bits) and loads the default limits.
module per_channel_sample_statistics (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pcss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pcss_pkg::CFG_DATA_W-1:0]   cfg_data,
    pcss_in_if.sink                           sample_in,
    pcss_out_if.source                        report_out
);
    import pcss_pkg::*;

    typedef struct packed {
        logic [1:0]             channel_index;
        logic [OUT_COUNT_W-1:0] sample_count;
        logic [SUM_W-1:0]       code_sum;
        logic [SQ_SUM_W-1:0]    code_square_sum;
        logic [CODE_W-1:0]      min_code;
        logic [CODE_W-1:0]      max_code;
        logic [OUT_COUNT_W-1:0] over_count;
        logic [OUT_COUNT_W-1:0] under_count;
        logic [OUT_COUNT_W-1:0] fault_count;
        logic [OUT_COUNT_W-1:0] gap_count;
        logic [OUT_COUNT_W-1:0] anomaly_count;
        logic                   last;
    } out_item_t;

    // Configuration registers.
    logic [CODE_W-1:0]        over_limit_reg;
    logic [CODE_W-1:0]        under_limit_reg;
    logic signed [15:0]       temp_high_reg;
    logic signed [15:0]       temp_low_reg;

    // Report sweep.
    logic                     sweep_active_reg;
    logic [CHAN_IDX_W-1:0]    sweep_idx_reg;

    // Update stage.
    logic                     s1_valid_reg;
    logic                     s1_rep_reg;
    logic [CHAN_IDX_W-1:0]    s1_addr_reg;
    logic                     s1_in_range_reg;
    logic                     s1_last_reg;
    logic [CODE_W-1:0]        s1_code_reg;
    logic [SQUARE_W-1:0]      s1_square_reg;
    logic                     s1_fault_reg;
    logic [31:0]              s1_seq_reg;
    logic signed [15:0]       s1_temp_reg;

    // Global statistics.
    logic [31:0]              prev_seq_reg;
    logic                     have_prev_reg;
    logic [COUNT_BITS-1:0]    gap_reg;
    logic [COUNT_BITS-1:0]    anomaly_reg;

    // Output register.
    logic                     out_valid_reg;
    out_item_t                out_item_reg;

    logic                     s1_go;
    logic                     in_xfer;
    logic                     issue_sample;
    logic                     issue_sweep;
    logic                     sample_go;
    logic                     report_go;
    logic [SQUARE_W-1:0]      square_in;
    store_rd_t                rd;
    store_wr_t                wr;
    stat_rec_t                cur_rec;
    stat_rec_t                upd_rec;

    // Handshake and stage control.
    always_comb
    begin
        s1_go           = !s1_valid_reg || !s1_rep_reg || !out_valid_reg || report_out.ready;
        sample_in.ready = s1_go && !sweep_active_reg;
        in_xfer         = sample_in.valid && sample_in.ready;
        issue_sample    = in_xfer && (sample_in.opcode == OP_SAMPLE);
        issue_sweep     = s1_go && sweep_active_reg;
        sample_go       = s1_valid_reg && !s1_rep_reg && s1_go;
        report_go       = s1_valid_reg && s1_rep_reg && s1_go;
        square_in       = SQUARE_W'(sample_in.raw_code) * SQUARE_W'(sample_in.raw_code);
        rd.addr         = sweep_active_reg ? sweep_idx_reg
                                           : sample_in.channel[CHAN_IDX_W-1:0];
        wr.we           = s1_valid_reg && s1_go && (s1_rep_reg || s1_in_range_reg);
        wr.addr         = s1_addr_reg;
        wr.data         = s1_rep_reg ? RESET_REC : upd_rec;
        wr.set_valid    = !s1_rep_reg;
    end

    pcss_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_go),
        .rd      (rd),
        .wr      (wr),
        .rec     (cur_rec)
    );

    pcss_update u_update (
        .rec_in      (cur_rec),
        .code        (s1_code_reg),
        .square      (s1_square_reg),
        .fault       (s1_fault_reg),
        .over_limit  (over_limit_reg),
        .under_limit (under_limit_reg),
        .rec_out     (upd_rec)
    );

    // Configuration write decoder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_limit_reg  <= 12'd3722;
            under_limit_reg <= 12'd373;
            temp_high_reg   <= 16'sd500;
            temp_low_reg    <= 16'sd100;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OVER_LIMIT:  over_limit_reg  <= cfg_data[CODE_W-1:0];
                REG_UNDER_LIMIT: under_limit_reg <= cfg_data[CODE_W-1:0];
                REG_TEMP_HIGH:   temp_high_reg   <= signed'(cfg_data);
                REG_TEMP_LOW:    temp_low_reg    <= signed'(cfg_data);
                default:         ;
            endcase
        end
    end

    // Stage control, sweep, global counters and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_active_reg <= 1'b0;
            sweep_idx_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s1_rep_reg       <= 1'b0;
            prev_seq_reg     <= '0;
            have_prev_reg    <= 1'b0;
            gap_reg          <= '0;
            anomaly_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_xfer && (sample_in.opcode == OP_REPORT))
            begin
                sweep_active_reg <= 1'b1;
                sweep_idx_reg    <= '0;
            end
            else if (issue_sweep)
            begin
                if (sweep_idx_reg == LAST_CHAN)
                begin
                    sweep_active_reg <= 1'b0;
                end
                sweep_idx_reg <= sweep_idx_reg + CHAN_IDX_W'(1);
            end

            if (s1_go)
            begin
                s1_valid_reg <= issue_sample || issue_sweep;
                s1_rep_reg   <= issue_sweep;
            end

            // Every sample takes part in the gap and temperature checks.
            if (sample_go)
            begin
                if (have_prev_reg && (s1_seq_reg != prev_seq_reg + 32'd1))
                begin
                    gap_reg <= sat_inc(gap_reg);
                end
                if ((s1_temp_reg > temp_high_reg) || (s1_temp_reg < temp_low_reg))
                begin
                    anomaly_reg <= sat_inc(anomaly_reg);
                end
                prev_seq_reg  <= s1_seq_reg;
                have_prev_reg <= 1'b1;
            end
            else if (report_go && s1_last_reg)
            begin
                prev_seq_reg  <= '0;
                have_prev_reg <= 1'b0;
                gap_reg       <= '0;
                anomaly_reg   <= '0;
            end

            if (report_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage and output payload.
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s1_addr_reg     <= rd.addr;
            s1_in_range_reg <= sample_in.channel < 8'(CHANNELS);
            s1_last_reg     <= sweep_idx_reg == LAST_CHAN;
            s1_code_reg     <= sample_in.raw_code;
            s1_square_reg   <= square_in;
            s1_fault_reg    <= sample_in.status_bits[0];
            s1_seq_reg      <= sample_in.seq_number;
            s1_temp_reg     <= sample_in.temperature;
        end
        if (report_go)
        begin
            out_item_reg.channel_index   <= 2'(s1_addr_reg);
            out_item_reg.sample_count    <= to_out_count(cur_rec.count);
            out_item_reg.code_sum        <= cur_rec.sum;
            out_item_reg.code_square_sum <= cur_rec.square_sum;
            out_item_reg.min_code        <= cur_rec.min_code;
            out_item_reg.max_code        <= cur_rec.max_code;
            out_item_reg.over_count      <= to_out_count(cur_rec.over);
            out_item_reg.under_count     <= to_out_count(cur_rec.under);
            out_item_reg.fault_count     <= to_out_count(cur_rec.fault);
            out_item_reg.gap_count       <= to_out_count(gap_reg);
            out_item_reg.anomaly_count   <= to_out_count(anomaly_reg);
            out_item_reg.last            <= s1_last_reg;
        end
    end

    // Output channel.
    assign report_out.valid           = out_valid_reg;
    assign report_out.channel_index   = out_item_reg.channel_index;
    assign report_out.sample_count    = out_item_reg.sample_count;
    assign report_out.code_sum        = out_item_reg.code_sum;
    assign report_out.code_square_sum = out_item_reg.code_square_sum;
    assign report_out.min_code        = out_item_reg.min_code;
    assign report_out.max_code        = out_item_reg.max_code;
    assign report_out.over_count      = out_item_reg.over_count;
    assign report_out.under_count     = out_item_reg.under_count;
    assign report_out.fault_count     = out_item_reg.fault_count;
    assign report_out.gap_count       = out_item_reg.gap_count;
    assign report_out.anomaly_count   = out_item_reg.anomaly_count;
    assign report_out.last            = out_item_reg.last;
endmodule

>>> rtl/pcss_store.sv
module pcss_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  pcss_pkg::store_rd_t  rd,
    input  pcss_pkg::store_wr_t  wr,
    output pcss_pkg::stat_rec_t  rec
);
    import pcss_pkg::*;

    stat_rec_t               mem [CHANNELS];
    logic [CHANNELS-1:0]     valid_reg;
    stat_rec_t               rd_data_reg;
    logic                    rd_valid_reg;
    logic                    fwd_hit_reg;
    stat_rec_t               fwd_data_reg;

    // Memory write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (advance)
        begin
            rd_data_reg  <= mem[rd.addr];
            fwd_data_reg <= wr.data;
        end
    end

    // Entry valid bits and the bypass of a write that lands on the entry being read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= wr.set_valid;
            end
            if (advance)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
                fwd_hit_reg  <= wr.we && (wr.addr == rd.addr);
            end
        end
    end

    // An entry never written since reset or report reads as the reset record.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            rec = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rec = rd_data_reg;
        end
        else
        begin
            rec = RESET_REC;
        end
    end
endmodule

>>> rtl/pcss_update.sv
module pcss_update (
    input  pcss_pkg::stat_rec_t          rec_in,
    input  logic [pcss_pkg::CODE_W-1:0]  code,
    input  logic [pcss_pkg::SQUARE_W-1:0] square,
    input  logic                         fault,
    input  logic [pcss_pkg::CODE_W-1:0]  over_limit,
    input  logic [pcss_pkg::CODE_W-1:0]  under_limit,
    output pcss_pkg::stat_rec_t          rec_out
);
    import pcss_pkg::*;

    logic [SUM_W:0]    sum_wide;
    logic [SQ_SUM_W:0] sq_wide;

    // Accumulate one sample into a channel record, saturating every count and sum.
    always_comb
    begin
        sum_wide = {1'b0, rec_in.sum} + (SUM_W + 1)'(code);
        sq_wide  = {1'b0, rec_in.square_sum} + (SQ_SUM_W + 1)'(square);

        rec_out            = rec_in;
        rec_out.count      = sat_inc(rec_in.count);
        rec_out.sum        = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        rec_out.square_sum = sq_wide[SQ_SUM_W] ? '1 : sq_wide[SQ_SUM_W-1:0];
        if (code < rec_in.min_code)
        begin
            rec_out.min_code = code;
        end
        if (code > rec_in.max_code)
        begin
            rec_out.max_code = code;
        end
        if (code > over_limit)
        begin
            rec_out.over = sat_inc(rec_in.over);
        end
        if (code < under_limit)
        begin
            rec_out.under = sat_inc(rec_in.under);
        end
        if (fault)
        begin
            rec_out.fault = sat_inc(rec_in.fault);
        end
    end
endmodule

>>> test/tb_per_channel_sample_statistics.sv
`timescale 1ns / 1ps

module tb_per_channel_sample_statistics;

    import pcss_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_OFF       = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_ROWS  = 19;

    // One input transfer, plus a mark for rows whose report is typed in as empty.
    typedef struct packed {
        logic               opcode;
        logic [7:0]         channel;
        logic [11:0]        code;
        logic [7:0]         status;
        logic [31:0]        seq;
        logic signed [15:0] temp;
        logic               typed_empty;
    } stim_row_t;

    // One channel report as it leaves the block.
    typedef struct packed {
        logic [1:0]  channel_index;
        logic [23:0] sample_count;
        logic [35:0] code_sum;
        logic [47:0] code_square_sum;
        logic [11:0] min_code;
        logic [11:0] max_code;
        logic [23:0] over_count;
        logic [23:0] under_count;
        logic [23:0] fault_count;
        logic [23:0] gap_count;
        logic [23:0] anomaly_count;
        logic        last;
    } report_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pcss_in_if  sample_in();
    pcss_out_if report_out();

    per_channel_sample_statistics dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .report_out (report_out)
    );

    // Limits as the block should hold them.
    logic [11:0]        over_limit;
    logic [11:0]        under_limit;
    logic signed [15:0] temp_high;
    logic signed [15:0] temp_low;

    // Statistics store as the block should hold it.
    logic [COUNT_BITS-1:0] ch_samples [CHANNELS];
    logic [SUM_W-1:0]      ch_sum   [CHANNELS];
    logic [SQ_SUM_W-1:0]   ch_sq    [CHANNELS];
    logic [CODE_W-1:0]     ch_min   [CHANNELS];
    logic [CODE_W-1:0]     ch_max   [CHANNELS];
    logic [COUNT_BITS-1:0] ch_over  [CHANNELS];
    logic [COUNT_BITS-1:0] ch_under [CHANNELS];
    logic [COUNT_BITS-1:0] ch_fault [CHANNELS];
    logic [31:0]           last_seq;
    bit                    seq_seen;
    logic [COUNT_BITS-1:0] gap_total;
    logic [COUNT_BITS-1:0] anomaly_total;

    report_t     owed_reports[$];
    int          failures = 0;
    int          reports_checked = 0;
    bit          steady = 1'b0;
    logic [31:0] next_seq = 32'd0;

    // Directed stimulus. Reports marked as typed are checked against an empty store.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_REPORT, 8'hA5, 12'hFFF, 8'hFF, 32'hFFFF_FFFF, -16'sd1,   1'b1},
        '{OP_REPORT, 8'h00, 12'h000, 8'h00, 32'h0000_0000, 16'sd0,    1'b1},
        '{OP_SAMPLE, 8'd0,  12'd0,   8'h00, 32'hFFFF_FFFE, 16'sd0,    1'b0},
        '{OP_SAMPLE, 8'd0,  12'd4095, 8'hFF, 32'hFFFF_FFFF, 16'sh7FFF, 1'b0},
        '{OP_SAMPLE, 8'd1,  12'd3722, 8'h01, 32'h0000_0000, 16'sd500, 1'b0},
        '{OP_SAMPLE, 8'd1,  12'd3723, 8'hFE, 32'h0000_0001, 16'sd501, 1'b0},
        '{OP_SAMPLE, 8'd2,  12'd373, 8'h00, 32'h0000_0005, 16'sd100,  1'b0},
        '{OP_SAMPLE, 8'd2,  12'd372, 8'h01, 32'h0000_0006, 16'sd99,   1'b0},
        '{OP_SAMPLE, 8'd4,  12'd2048, 8'h01, 32'h0000_0007, 16'sh8000, 1'b0},
        '{OP_SAMPLE, 8'd255, 12'd4095, 8'hFF, 32'h8000_0000, -16'sd1, 1'b0},
        '{OP_SAMPLE, 8'd3,  12'd1234, 8'hAA, 32'h8000_0001, 16'sd250, 1'b0},
        '{OP_SAMPLE, 8'd3,  12'd1234, 8'h55, 32'h8000_0002, 16'sd250, 1'b0},
        '{OP_REPORT, 8'h55, 12'hAAA, 8'h01, 32'h1234_5678, -16'sd5,   1'b0},
        '{OP_SAMPLE, 8'd3,  12'd4095, 8'h00, 32'h5555_AAAA, 16'sd300, 1'b0},
        '{OP_SAMPLE, 8'd3,  12'd0,   8'h01, 32'hAAAA_5555, 16'sd300,  1'b0},
        '{OP_SAMPLE, 8'd128, 12'hAAA, 8'h55, 32'h0000_0000, 16'sh5555, 1'b0},
        '{OP_SAMPLE, 8'd1,  12'h555, 8'hAA, 32'h0000_0001, 16'shAAAA, 1'b0},
        '{OP_REPORT, 8'hFF, 12'h555, 8'hAA, 32'hDEAD_0000, 16'sd700,  1'b0},
        '{OP_REPORT, 8'h02, 12'h001, 8'h01, 32'h0000_0002, 16'sd0,    1'b1}
    };

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturating count.
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Report of a channel with no samples since the last clear.
    function automatic report_t empty_report(input int c);
        report_t r;
        r.channel_index   = 2'(c);
        r.sample_count    = 24'd0;
        r.code_sum        = 36'd0;
        r.code_square_sum = 48'd0;
        r.min_code        = 12'd4095;
        r.max_code        = 12'd0;
        r.over_count      = 24'd0;
        r.under_count     = 24'd0;
        r.fault_count     = 24'd0;
        r.gap_count       = 24'd0;
        r.anomaly_count   = 24'd0;
        r.last            = (c == CHANNELS - 1);
        return r;
    endfunction

    // Return the store to its cleared state.
    function automatic void clear_stats();
        for (int c = 0; c < CHANNELS; c++)
        begin
            ch_samples[c] = '0;
            ch_sum[c]   = '0;
            ch_sq[c]    = '0;
            ch_min[c]   = 12'd4095;
            ch_max[c]   = '0;
            ch_over[c]  = '0;
            ch_under[c] = '0;
            ch_fault[c] = '0;
        end
        last_seq      = '0;
        seq_seen      = 1'b0;
        gap_total     = '0;
        anomaly_total = '0;
    endfunction

    // Advance the expected store by one accepted transfer, queueing any reports.
    function automatic void update_statistics(input stim_row_t it);
        report_t            r;
        logic [SUM_W:0]     sum_next;
        logic [SQ_SUM_W:0]  sq_next;
        logic [SQUARE_W-1:0] square;
        int                 c;
        if (it.opcode == OP_REPORT)
        begin
            for (c = 0; c < CHANNELS; c++)
            begin
                r.channel_index   = 2'(c);
                r.sample_count    = ch_samples[c];
                r.code_sum        = ch_sum[c];
                r.code_square_sum = ch_sq[c];
                r.min_code        = ch_min[c];
                r.max_code        = ch_max[c];
                r.over_count      = ch_over[c];
                r.under_count     = ch_under[c];
                r.fault_count     = ch_fault[c];
                r.gap_count       = gap_total;
                r.anomaly_count   = anomaly_total;
                r.last            = (c == CHANNELS - 1);
                owed_reports.push_back(r);
            end
            clear_stats();
            return;
        end
        // Per-channel statistics only for channels that exist.
        if (it.channel < CHANNELS)
        begin
            c           = int'(it.channel);
            ch_samples[c] = bump(ch_samples[c]);
            sum_next    = ch_sum[c] + it.code;
            ch_sum[c]   = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
            square      = it.code * it.code;
            sq_next     = ch_sq[c] + square;
            ch_sq[c]    = sq_next[SQ_SUM_W] ? '1 : sq_next[SQ_SUM_W-1:0];
            if (it.code < ch_min[c])
                ch_min[c] = it.code;
            if (it.code > ch_max[c])
                ch_max[c] = it.code;
            if (it.code > over_limit)
                ch_over[c] = bump(ch_over[c]);
            if (it.code < under_limit)
                ch_under[c] = bump(ch_under[c]);
            if (it.status[0])
                ch_fault[c] = bump(ch_fault[c]);
        end
        // Sequence and temperature checks apply to every sample.
        if (seq_seen && it.seq != last_seq + 32'd1)
            gap_total = bump(gap_total);
        last_seq = it.seq;
        seq_seen = 1'b1;
        if ($signed(it.temp) > $signed(temp_high) || $signed(it.temp) < $signed(temp_low))
            anomaly_total = bump(anomaly_total);
    endfunction

    // Random transfer: mostly samples on real channels with consecutive sequence numbers.
    function automatic stim_row_t random_item();
        stim_row_t it;
        it.typed_empty = 1'b0;
        it.opcode      = ($urandom_range(0, 11) == 0) ? OP_REPORT : OP_SAMPLE;
        it.channel     = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                                     : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 11))
            0:       it.code = over_limit;
            1:       it.code = over_limit + 12'd1;
            2:       it.code = under_limit;
            3:       it.code = under_limit - 12'd1;
            4:       it.code = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
            default: it.code = 12'($urandom_range(0, 4095));
        endcase
        it.status = 8'($urandom_range(0, 255));
        it.seq    = ($urandom_range(0, 7) != 0) ? next_seq : 32'($urandom());
        case ($urandom_range(0, 3))
            0:       it.temp = temp_high - 16'sd1 + 16'($urandom_range(0, 2));
            1:       it.temp = temp_low - 16'sd1 + 16'($urandom_range(0, 2));
            2:       it.temp = 16'($urandom());
            default: it.temp = 16'($urandom_range(0, 700)) - 16'sd100;
        endcase
        if (it.opcode == OP_SAMPLE)
            next_seq = it.seq + 32'd1;
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // Compare one report transfer with the oldest owed report.
    function automatic void check_report();
        report_t want;
        if (owed_reports.size() == 0)
        begin
            $error("report transfer for channel %0d with none owed", report_out.channel_index);
            failures++;
            return;
        end
        want = owed_reports.pop_front();
        check_field("channel_index", want.channel_index, report_out.channel_index);
        check_field("sample_count", want.sample_count, report_out.sample_count);
        check_field("code_sum", want.code_sum, report_out.code_sum);
        check_field("code_square_sum", want.code_square_sum, report_out.code_square_sum);
        check_field("min_code", want.min_code, report_out.min_code);
        check_field("max_code", want.max_code, report_out.max_code);
        check_field("over_count", want.over_count, report_out.over_count);
        check_field("under_count", want.under_count, report_out.under_count);
        check_field("fault_count", want.fault_count, report_out.fault_count);
        check_field("gap_count", want.gap_count, report_out.gap_count);
        check_field("anomaly_count", want.anomaly_count, report_out.anomaly_count);
        check_field("last", want.last, report_out.last);
        reports_checked++;
    endfunction

    // Offer one transfer, with an optional idle burst first, and wait for it to be taken.
    task automatic send_item(input stim_row_t it);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            sample_in.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        sample_in.valid       <= 1'b1;
        sample_in.opcode      <= it.opcode;
        sample_in.channel     <= it.channel;
        sample_in.raw_code    <= it.code;
        sample_in.status_bits <= it.status;
        sample_in.seq_number  <= it.seq;
        sample_in.temperature <= it.temp;
        @(posedge clk);
        while (!sample_in.ready)
            @(posedge clk);
        if (it.typed_empty)
        begin
            for (int c = 0; c < CHANNELS; c++)
                owed_reports.push_back(empty_report(c));
            clear_stats();
        end
        else
        begin
            update_statistics(it);
        end
    endtask

    // Wait until every owed report has arrived and the pipeline has emptied.
    task automatic wait_drained();
        while (owed_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four limits; the 12-bit limits are written with junk in the unused upper data bits.
    task automatic program_limits(input logic [11:0] over_code, input logic [11:0] under_code,
                                  input logic signed [15:0] high_temp,
                                  input logic signed [15:0] low_temp);
        cfg_write <= 1'b1;
        cfg_index <= REG_OVER_LIMIT;
        cfg_data  <= {4'($urandom()), over_code};
        @(posedge clk);
        cfg_index <= REG_UNDER_LIMIT;
        cfg_data  <= {4'($urandom()), under_code};
        @(posedge clk);
        cfg_index <= REG_TEMP_HIGH;
        cfg_data  <= high_temp;
        @(posedge clk);
        cfg_index <= REG_TEMP_LOW;
        cfg_data  <= low_temp;
        @(posedge clk);
        cfg_write   <= 1'b0;
        over_limit  = over_code;
        under_limit = under_code;
        temp_high   = high_temp;
        temp_low    = low_temp;
    endtask

    // Random transfers closed by a report, so the phase ends with nothing owed.
    task automatic run_random_phase(input int count);
        stim_row_t closing;
        for (int n = 0; n < count; n++)
            send_item(random_item());
        closing        = random_item();
        closing.opcode = OP_REPORT;
        send_item(closing);
        sample_in.valid <= 1'b0;
        wait_drained();
    endtask

    // Report receiver with random stalls and one long hold-off while the sender is busy.
    initial
    begin : report_sink
        int stall_left;
        bit held_long;
        stall_left = 0;
        held_long  = 1'b0;
        report_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && report_out.valid && report_out.ready)
                check_report();
            if (stall_left > 0)
            begin
                stall_left--;
                report_out.ready <= 1'b0;
            end
            else if (!held_long && reports_checked >= 40 && sample_in.valid)
            begin
                held_long  = 1'b1;
                stall_left = HOLD_OFF - 1;
                report_out.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                report_out.ready <= 1'b0;
            end
            else
            begin
                report_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_in.valid && sample_in.ready) || (report_out.valid && report_out.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("per_channel_sample_statistics test failed");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table at reset limits, then random phases.
    initial
    begin
        rst_n                 <= 1'b0;
        cfg_write             <= 1'b0;
        cfg_index             <= REG_OVER_LIMIT;
        cfg_data              <= '0;
        sample_in.valid       <= 1'b0;
        sample_in.opcode      <= OP_SAMPLE;
        sample_in.channel     <= '0;
        sample_in.raw_code    <= '0;
        sample_in.status_bits <= '0;
        sample_in.seq_number  <= '0;
        sample_in.temperature <= '0;
        over_limit  = 12'd3722;
        under_limit = 12'd373;
        temp_high   = 16'sd500;
        temp_low    = 16'sd100;
        clear_stats();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_rows[i]);
        sample_in.valid <= 1'b0;
        wait_drained();

        // Nothing can count as over, under or anomalous.
        program_limits(12'd4095, 12'd0, 16'sh7FFF, 16'sh8000);
        run_random_phase(60);

        // Nearly everything counts.
        program_limits(12'd0, 12'd4095, 16'sh8000, 16'sh7FFF);
        run_random_phase(60);

        program_limits(12'($urandom()), 12'($urandom()), 16'($urandom()), 16'($urandom()));
        run_random_phase(60);

        // Last part runs without idling on either side.
        steady = 1'b1;
        program_limits(12'd2000, 12'd1000, 16'sd300, -16'sd300);
        run_random_phase(70);

        if (failures == 0)
            $display("per_channel_sample_statistics test passed");
        else
            $display("per_channel_sample_statistics test failed");
        $finish;
    end

endmodule
